>>> hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for the GF(2) greedy basis selector
// Holds the sequencer states, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // Fixed field widths
  localparam int unsigned VecW  = 64;  // operator vector
  localparam int unsigned CntW  = 7;   // basis size and register values
  localparam int unsigned SeqW  = 16;  // saturating item index
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutW  = 32;  // result tdata, padded to whole bytes

  // Register indexes on the write port
  localparam logic [CfgIdxW-1:0] CFG_NUM_VARS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BASIS = 2'd1;

  localparam logic [CntW-1:0] CFG_RESET_VAL = 7'd64;
  localparam logic [SeqW-1:0] SEQ_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/gf2_greedy_basis_select.sv
// ----------------------------------------------------------------------------
// gf2_greedy_basis_select: greedy selection of independent vectors over GF(2)
// Reduces each masked vector against pivots kept by leading bit and stores the
// remainder as a new pivot when it is nonzero, until the basis is full.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake           | Payload
//  ----------+-----------+---------------------+-------------------------------
//  s_axis    | in        | tvalid / tready     | tdata: vector_bits; tuser: first
//  m_axis    | out       | tvalid / tready     | tdata: accepted, basis_size,
//            |           |                     |        item_index, complete
//  cfg       | in        | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
//  An item that is reduced is scanned against the pivot slots one at a time,
//  from the top slot down, as the pivot memory has a single read port; the
//  sequencer then loads the result register and returns to idle. An item that
//  arrives with the basis full skips the scan and goes straight to the result.
//  Reset clears the valid bits in flip-flops at once; no clearing pass.
//  A stalled result holds in the output register; the next item is accepted
//  meanwhile, and its result waits in the sequencer until the register frees.
//
module gf2_greedy_basis_select #(
  parameter int unsigned MAX_VARS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [gbs_pkg::VecW-1:0]     s_axis_tdata_i,   // [63:0] vector_bits
  input  logic [0:0]                   s_axis_tuser_i,   // [0] first
  // result items
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [gbs_pkg::OutW-1:0]     m_axis_tdata_o,   // [0] accepted, [7:1] basis_size,
                                                         // [23:8] item_index, [24] complete
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [gbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gbs_pkg::CntW-1:0]     cfg_wdata_i
);

  import gbs_pkg::*;

  localparam int unsigned PosW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam logic [PosW-1:0] PosTop = PosW'(MAX_VARS - 1);
  localparam logic [CntW-1:0] VarsMax = CntW'(MAX_VARS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CntW-1:0]       num_vars_q, max_basis_q;
  logic [MAX_VARS-1:0]   valid_q;
  logic [CntW-1:0]       basis_q;
  logic [SeqW-1:0]       seq_q;

  logic [MAX_VARS-1:0]   vec_q, vec_d;
  logic [PosW-1:0]       pos_q;
  logic                  found_q, found_d;
  logic [PosW-1:0]       lead_q, lead_d;
  logic                  acc_q;
  logic [SeqW-1:0]       idx_q;

  logic                  m_valid_q;
  logic [OutW-1:0]       m_data_q;

  // pivot memory, one entry per leading bit
  logic [MAX_VARS-1:0]   pivot_mem [MAX_VARS];
  logic [MAX_VARS-1:0]   rd_data_q;
  logic [PosW-1:0]       rd_addr;

  // --------------------------------------------------------------------------
  // Effective limits and input mask
  // --------------------------------------------------------------------------
  logic [CntW-1:0]       eff_vars, limit;
  logic [MAX_VARS-1:0]   mask;

  assign eff_vars = (num_vars_q > VarsMax) ? VarsMax : num_vars_q;
  assign limit    = (max_basis_q < eff_vars) ? max_basis_q : eff_vars;

  always_comb begin
    for (int i = 0; i < MAX_VARS; i++) begin
      mask[i] = (CntW'(i) < eff_vars);
    end
  end

  // Starting state for an accepted item: a first item clears the basis
  logic                  in_first;
  logic [CntW-1:0]       basis_base;
  logic [SeqW-1:0]       seq_base;
  logic                  room;

  assign in_first   = s_axis_tuser_i[0];
  assign basis_base = in_first ? '0 : basis_q;
  assign seq_base   = in_first ? '0 : seq_q;
  assign room       = (basis_base < limit);

  // --------------------------------------------------------------------------
  // Reduction step: pivot for bit pos_q arrived from the memory last cycle.
  // A pivot only touches bits at or below its leading bit, so bit pos_q is
  // final after this step; it survives exactly when no pivot owns it.
  // --------------------------------------------------------------------------
  logic hit, keep, last_step;

  assign hit       = vec_q[pos_q] & valid_q[pos_q];
  assign keep      = vec_q[pos_q] & ~valid_q[pos_q];
  assign last_step = (pos_q == '0);

  always_comb begin
    vec_d   = hit ? (vec_q ^ rd_data_q) : vec_q;
    found_d = found_q | keep;
    lead_d  = (keep && !found_q) ? pos_q : lead_q;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  logic in_fire, out_free;

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = room ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  logic load_out, commit;

  always_comb begin
    s_axis_tready_o = 1'b0;
    load_out        = 1'b0;
    commit          = 1'b0;
    rd_addr         = PosTop;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      S_SCAN: begin
        // fetch the next lower pivot while this one is applied
        rd_addr = pos_q - PosW'(1);
        commit  = last_step && found_d;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_vars_q  <= CFG_RESET_VAL;
      max_basis_q <= CFG_RESET_VAL;
      valid_q     <= '0;
      basis_q     <= '0;
      seq_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_VARS:  num_vars_q  <= cfg_wdata_i;
          CFG_MAX_BASIS: max_basis_q <= cfg_wdata_i;
          default: ;  // drop writes to unknown indexes
        endcase
      end

      if (in_fire) begin
        if (in_first) begin
          valid_q <= '0;
          basis_q <= '0;
        end
        seq_q <= (seq_base != SEQ_MAX) ? seq_base + SeqW'(1) : seq_base;
      end

      if (commit) begin
        valid_q[lead_d] <= 1'b1;
        basis_q         <= basis_q + CntW'(1);
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vec_q   <= s_axis_tdata_i[MAX_VARS-1:0] & mask;
      pos_q   <= PosTop;
      found_q <= 1'b0;
      lead_q  <= '0;
      acc_q   <= 1'b0;
      idx_q   <= seq_base;
    end else if (state_q == S_SCAN) begin
      vec_q   <= vec_d;
      pos_q   <= pos_q - PosW'(1);
      found_q <= found_d;
      lead_q  <= lead_d;
      if (commit) begin
        acc_q <= 1'b1;
      end
    end

    if (load_out) begin
      m_data_q <= {(OutW - 25)'(0), (basis_q >= limit), idx_q, basis_q, acc_q};
    end
  end

  // pivot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (commit) begin
      pivot_mem[lead_d] <= vec_d;
    end
    rd_data_q <= pivot_mem[rd_addr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the basis size always matches the number of occupied pivot slots
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == basis_q)
    else $error("basis count differs from occupied pivot slots");

  // an accepted item leaves idle before the next one can be taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input ready straight after an accepted item");

  // a result that reports acceptance has a nonempty basis
  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[7:1] != '0))
    else $error("accepted result with empty basis");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gf2_greedy_basis_select
// Streams ranked operator vectors through the selector with random gaps and
// output stalls, tracks its own pivot basis per item and compares each result
// field by field. Covers the register extremes, the full-basis path and a
// limit widened in mid-sequence.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_VARS     = 64;
  localparam int unsigned HOLD_CYCLES  = 500;   // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 80;    // settle time before a register write
  localparam int unsigned STUCK_LIMIT  = 3000;  // cycles without any handshake

  // Indexes with no register behind them; writes there must be dropped
  localparam logic [gbs_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [gbs_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  basis_size;
    logic [15:0] item_index;
    logic        complete;
  } selection_t;

  // Tracks the pivot basis on the bench side and holds the selections still
  // owed by the block, oldest first.
  class selection_board;
    logic [63:0]  pivots [64];
    logic [63:0]  pivot_live;
    int unsigned  rank;
    int unsigned  next_index;
    logic [6:0]   num_vars;
    logic [6:0]   max_basis;
    selection_t   awaited [$];
    int unsigned  faults;

    function new();
      pivot_live = '0;
      rank       = 0;
      next_index = 0;
      num_vars   = gbs_pkg::CFG_RESET_VAL;
      max_basis  = gbs_pkg::CFG_RESET_VAL;
      faults     = 0;
    endfunction

    function void write_reg(logic [gbs_pkg::CfgIdxW-1:0] idx, logic [6:0] val);
      case (idx)
        gbs_pkg::CFG_NUM_VARS:  num_vars  = val;
        gbs_pkg::CFG_MAX_BASIS: max_basis = val;
        default: ;
      endcase
    endfunction

    // Reduce one vector against the live pivots and queue the selection.
    function void note_vector(logic [63:0] raw, logic first);
      int unsigned width;
      int unsigned limit;
      logic [63:0] keep;
      logic [63:0] rem;
      selection_t  sel;
      int          lead;
      width = (num_vars > MAX_VARS) ? MAX_VARS : num_vars;
      limit = (max_basis < width) ? max_basis : width;
      keep  = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
      rem   = raw & keep;
      if (first) begin
        pivot_live = '0;
        rank       = 0;
        next_index = 0;
      end
      sel.item_index = 16'(next_index);
      if (next_index < 65535) next_index++;
      sel.accepted = 1'b0;
      if (rank < limit) begin
        for (int b = 63; b >= 0; b--)
          if (rem[b] && pivot_live[b]) rem ^= pivots[b];
        if (rem != '0) begin
          lead = 0;
          for (int b = 0; b < 64; b++)
            if (rem[b]) lead = b;
          pivots[lead]     = rem;
          pivot_live[lead] = 1'b1;
          rank++;
          sel.accepted = 1'b1;
        end
      end
      sel.basis_size = 7'(rank);
      sel.complete   = (rank >= limit);
      awaited = {awaited, sel};
    endfunction

    function void check_selection(logic [gbs_pkg::OutW-1:0] word);
      selection_t want;
      selection_t got;
      got.accepted   = word[0];
      got.basis_size = word[7:1];
      got.item_index = word[23:8];
      got.complete   = word[24];
      if (awaited.size() == 0) begin
        $error("result with no vector outstanding: tdata %h", word);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
        faults++;
      end
      if (got.basis_size !== want.basis_size) begin
        $error("basis_size: expected %0d, actual %0d", want.basis_size, got.basis_size);
        faults++;
      end
      if (got.item_index !== want.item_index) begin
        $error("item_index: expected %0d, actual %0d", want.item_index, got.item_index);
        faults++;
      end
      if (got.complete !== want.complete) begin
        $error("complete: expected %0d, actual %0d", want.complete, got.complete);
        faults++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [gbs_pkg::VecW-1:0]      s_axis_tdata_i;   // [63:0] vector_bits
  logic [0:0]                    s_axis_tuser_i;   // [0] first
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [gbs_pkg::OutW-1:0]      m_axis_tdata_o;   // [0] accepted, [7:1] basis_size,
                                                   // [23:8] item_index, [24] complete
  logic                          cfg_we_i;
  logic [gbs_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [gbs_pkg::CntW-1:0]      cfg_wdata_i;

  selection_board board = new();

  // Stimulus controls shared between the sender, the receiver and the phases
  bit          send_idle_on;
  bit          recv_idle_on;
  bit          hold_req;
  int unsigned cur_vars;
  logic [63:0] history [$];   // vectors of the current sequence, for dependent ones
  int unsigned stuck;

  gf2_greedy_basis_select #(
    .MAX_VARS (MAX_VARS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predict on every accepted input item, check every accepted result item.
  // Both sample the pre-edge values, so ordering within the step is irrelevant.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_vector(s_axis_tdata_i, s_axis_tuser_i[0]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_selection(m_axis_tdata_o);
    end
  end

  // Watchdog: give up when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stuck = 0;
    else
      stuck++;
    if (stuck == STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: draw a stall per result; honour a long hold-off when asked so
  // that the result register and the sequencer fill and the input backs up.
  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = recv_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Offer one item after a random gap and hold it until taken. Leave tvalid
  // high on return so a back-to-back item needs no second assignment.
  task automatic send_item(input logic [63:0] vec, input logic first);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= vec;
    s_axis_tuser_i  <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (first) history.delete();
    history = {history, vec};
    if (history.size() > 64) void'(history.pop_front());
  endtask

  // Drop tvalid, wait for every owed result, then let the sequencer settle.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gbs_pkg::CfgIdxW-1:0] idx, input logic [6:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Program both registers, with a write to an unused index slipped between.
  task automatic set_regs(input int unsigned nv, input int unsigned mb);
    write_reg(gbs_pkg::CFG_NUM_VARS, 7'(nv));
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 7'($urandom_range(0, 127)));
    write_reg(gbs_pkg::CFG_MAX_BASIS, 7'(mb));
    cfg_we_i <= 1'b0;
    cur_vars = nv;
  endtask

  // Mix of dense, sparse, dependent, zero and out-of-range vectors.
  function automatic logic [63:0] make_vector();
    logic [63:0] v;
    logic [63:0] keep;
    int unsigned pick;
    int unsigned top;
    int unsigned n;
    pick = $urandom_range(0, 99);
    keep = (cur_vars >= 64) ? '1 : ((64'd1 << cur_vars) - 64'd1);
    top  = (cur_vars == 0) ? 0 : ((cur_vars > 64) ? 63 : cur_vars - 1);
    n    = $urandom_range(1, 3);
    v    = {$urandom, $urandom};
    if (pick < 35) begin
      // dense random, kept as drawn
    end else if (pick < 55) begin
      v = '0;
      repeat (n) v[$urandom_range(0, top)] = 1'b1;
    end else if (pick < 80 && history.size() != 0) begin
      // combination of earlier vectors: dependent unless the basis was capped
      v = '0;
      repeat (n) v ^= history[$urandom_range(0, history.size() - 1)];
    end else if (pick < 85) begin
      v = '0;
    end else if (pick < 92) begin
      v = v & ~keep;   // only bits the mask throws away
    end else begin
      v = 64'd1 << $urandom_range(0, top);
    end
    return v;
  endfunction

  // One register setting, then runs of well-formed sequences with random
  // content; a few stray first flags break sequences up. With fresh clear the
  // phase carries on the basis left by the previous setting.
  task automatic run_phase(input int unsigned nv, input int unsigned mb,
                           input int unsigned count, input bit fresh, input bit squeeze);
    int unsigned left;
    int unsigned len;
    bit          lead_in;
    logic        first;
    quiesce();
    set_regs(nv, mb);
    send_idle_on = ($urandom_range(0, 3) != 0);
    recv_idle_on = ($urandom_range(0, 3) != 0);
    if (squeeze) hold_req = 1'b1;
    left    = count;
    lead_in = fresh;
    while (left > 0) begin
      len = $urandom_range(0, 1) ? $urandom_range(50, 90) : $urandom_range(1, 20);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if (k == 0) first = lead_in ? ($urandom_range(0, 9) != 0) : 1'b0;
        else        first = ($urandom_range(0, 49) == 0);
        send_item(make_vector(), first);
      end
      lead_in = 1'b1;
      left -= len;
    end
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    hold_req     = 1'b0;
    cur_vars     = gbs_pkg::CFG_RESET_VAL;
    stuck        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset register values: zero vector, all ones,
    // the end bits, dependent repeats and first flags clearing mid-run.
    send_item(64'h0, 1'b1);
    send_item('1, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b0);
    send_item(64'h1, 1'b0);
    send_item('1, 1'b0);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(64'h5555_5555_5555_5555, 1'b0);
    send_item(64'h8000_0000_0000_0001, 1'b0);
    send_item(64'h0, 1'b0);
    send_item('1, 1'b1);
    send_item(64'h0, 1'b1);
    send_item('1, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b0);

    // Register extremes and the special settings
    run_phase(8,   64,  100, 1'b1, 1'b0);
    run_phase(64,  5,   80,  1'b0, 1'b0);
    run_phase(0,   64,  30,  1'b1, 1'b0);
    run_phase(64,  0,   30,  1'b0, 1'b0);
    run_phase(127, 127, 180, 1'b1, 1'b1);
    run_phase(64,  64,  150, 1'b1, 1'b0);
    run_phase(1,   1,   40,  1'b0, 1'b0);
    run_phase(40,  100, 100, 1'b0, 1'b0);
    run_phase(100, 40,  100, 1'b1, 1'b0);
    repeat (4)
      run_phase($urandom_range(0, 127), $urandom_range(0, 127), 70,
                ($urandom_range(0, 1) != 0), 1'b0);

    // Hold the basis at a zero cap so every item passes straight through,
    // then widen the limit mid-sequence so vectors join the cleared basis.
    quiesce();
    set_regs(64, 0);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    for (int i = 0; i < 20; i++)
      send_item({$urandom, $urandom}, i == 0);
    quiesce();
    set_regs(16, 64);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (24) send_item(make_vector(), 1'b0);

    quiesce();
    if (board.faults == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
